@@ src/sab_pkg.sv @@
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants of the bitmap slot allocator
// Holds the request and status codes, the controller states and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sab_pkg;

    // Default sizes of the pool.
    localparam int NUM_SLOTS_DEF    = 256;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed widths of the request and response fields.
    localparam int OP_W      = 3;
    localparam int INDEX_W   = 9;
    localparam int PORT_PAY_W = 32;
    localparam int STATUS_W  = 2;

    // Request codes.
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_GET    = 3'd2,
        OP_NEXT   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } sab_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_req;
        logic scan_done;
    } sab_stat_t;

endpackage

@@ src/slot_allocator_bitmap.sv @@
// ----------------------------------------------------------------------------
// slot_allocator_bitmap: fixed pool of payload slots with an occupancy bitmap
// Add places a payload in the lowest free slot, remove frees a slot, get
// reads an occupied slot, next finds the first occupied slot after a start
// index and clear frees the whole pool. Each response carries the count.
//
//   Channel   Signals                                   Direction
//   request   in_valid, in_ready, op, slot_index,       in
//             payload_in
//   response  out_valid, out_ready, status,             out
//             result_index, payload_out, occupied_count
//
// A request is decoded in the cycle after its transfer; for remove, get and
// clear its response is valid in the cycle after the decode. Add to a pool
// with room and next from a valid start scan the bitmap one 32-bit word per
// cycle, over up to NUM_SLOTS/32 words (8 at the default size), until a hit
// or the last word. One request is in flight at a time; a new request is
// taken once the response has been transferred. Reset frees every slot at
// once; payload contents are not cleared.
// ----------------------------------------------------------------------------
module slot_allocator_bitmap
#(
    parameter int NUM_SLOTS    = sab_pkg::NUM_SLOTS_DEF,
    parameter int PAYLOAD_BITS = sab_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [sab_pkg::OP_W-1:0]              op,
    input  logic signed [sab_pkg::INDEX_W-1:0]    slot_index,
    input  logic [sab_pkg::PORT_PAY_W-1:0]        payload_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sab_pkg::STATUS_W-1:0]          status,
    output logic [sab_pkg::INDEX_W-1:0]           result_index,
    output logic [sab_pkg::PORT_PAY_W-1:0]        payload_out,
    output logic [sab_pkg::INDEX_W-1:0]           occupied_count
);
    import sab_pkg::*;

    sab_cmd_t  cmd;
    sab_stat_t stat;

    // Request sequencer.
    sab_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Bitmap, payload store and response registers.
    sab_datapath
    #(
        .NUM_SLOTS    (NUM_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .slot_index     (slot_index),
        .payload_in     (payload_in),
        .status         (status),
        .result_index   (result_index),
        .payload_out    (payload_out),
        .occupied_count (occupied_count)
    );

    // A response is never offered while a new request can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("response offered while a request is accepted");

    // A full pool reports the slot count as index and as occupied count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |->
        ((result_index == INDEX_W'(NUM_SLOTS)) &&
         (occupied_count == INDEX_W'(NUM_SLOTS))))
        else $error("full status without a full pool");

    // A response with a failing status carries a zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (payload_out == '0))
        else $error("payload returned with a failing status");

    // The occupied count never exceeds the pool size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((NUM_SLOTS > 511) ||
                       (occupied_count <= INDEX_W'(NUM_SLOTS))))
        else $error("occupied count beyond the pool size");

endmodule

@@ src/sab_ctrl.sv @@
// ----------------------------------------------------------------------------
// sab_ctrl: request sequencer of the bitmap slot allocator
// Takes one request, runs the decode cycle, steps the bitmap scan when the
// request needs one and holds the response until it has been transferred.
// ----------------------------------------------------------------------------
module sab_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sab_pkg::sab_cmd_t   cmd,
    input  sab_pkg::sab_stat_t  stat
);
    import sab_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.scan_req ? S_SCAN : S_RESP;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/sab_datapath.sv @@
// ----------------------------------------------------------------------------
// sab_datapath: bitmap, payload store and response registers
// Holds the occupancy bitmap, the occupied count and the payload memory,
// decodes the latched request and scans the bitmap one word per cycle.
// ----------------------------------------------------------------------------
module sab_datapath
#(
    parameter int NUM_SLOTS    = sab_pkg::NUM_SLOTS_DEF,
    parameter int PAYLOAD_BITS = sab_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sab_pkg::sab_cmd_t                     cmd,
    output sab_pkg::sab_stat_t                    stat,
    input  logic [sab_pkg::OP_W-1:0]              op,
    input  logic signed [sab_pkg::INDEX_W-1:0]    slot_index,
    input  logic [sab_pkg::PORT_PAY_W-1:0]        payload_in,
    output logic [sab_pkg::STATUS_W-1:0]          status,
    output logic [sab_pkg::INDEX_W-1:0]           result_index,
    output logic [sab_pkg::PORT_PAY_W-1:0]        payload_out,
    output logic [sab_pkg::INDEX_W-1:0]           occupied_count
);
    import sab_pkg::*;

    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int WORD_W    = (NUM_SLOTS < 32) ? (2 ** $clog2(NUM_SLOTS)) : 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WPTR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PAD_W     = NUM_WORDS * WORD_W;
    localparam int FULL_W    = WPTR_W + BIT_W;
    localparam int CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Latched request.
    logic [OP_W-1:0]          req_op_reg;
    logic signed [INDEX_W-1:0] req_idx_reg;
    logic [PAYLOAD_BITS-1:0]  req_pay_reg;

    // Pool state.
    logic [NUM_SLOTS-1:0]     occ_reg;
    logic [NUM_SLOTS-1:0]     occ_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;

    // Scan state.
    logic [WPTR_W-1:0]        ptr_reg;
    logic [WPTR_W-1:0]        ptr_next;
    logic                     first_reg;
    logic                     first_next;
    logic [BIT_W-1:0]         start_bit_reg;
    logic [BIT_W-1:0]         start_bit_next;

    // Response registers.
    status_t                  status_reg;
    status_t                  status_next;
    logic [INDEX_W-1:0]       res_idx_reg;
    logic [INDEX_W-1:0]       res_idx_next;
    logic                     pay_sel_reg;
    logic                     pay_sel_next;

    // Payload memory.
    logic [PAYLOAD_BITS-1:0]  store_mem [NUM_SLOTS];
    logic [PAYLOAD_BITS-1:0]  rdata_reg;
    logic                     mem_we;
    logic                     mem_re;

    // Request decode.
    logic                     idx_neg;
    logic                     in_range;
    logic                     next_ok;
    logic [IDX_W-1:0]         slot;
    logic [CMP_W-1:0]         start_val;
    logic                     start_ok;
    logic [FULL_W-1:0]        start_pos;
    logic                     full;
    logic                     is_add;

    // Word search.
    logic [NUM_SLOTS-1:0]     free_vec;
    logic [PAD_W-1:0]         search_vec;
    logic [FULL_W-1:0]        word_base;
    logic [WORD_W-1:0]        word;
    logic [WORD_W-1:0]        low_mask;
    logic [WORD_W-1:0]        masked;
    logic [BIT_W-1:0]         hit_pos;
    logic                     hit;
    logic                     last_word;
    logic [FULL_W-1:0]        found_idx;
    logic [IDX_W-1:0]         slot_found;

    // Index checks on the latched request.
    always_comb
    begin
        idx_neg   = req_idx_reg[INDEX_W-1];
        in_range  = !idx_neg &&
                    (CMP_W'(req_idx_reg[INDEX_W-2:0]) < CMP_W'(NUM_SLOTS));
        next_ok   = in_range || (&req_idx_reg);
        slot      = IDX_W'(req_idx_reg[INDEX_W-2:0]);
        start_val = idx_neg ? '0
                            : CMP_W'(req_idx_reg[INDEX_W-2:0]) + CMP_W'(1);
        start_ok  = start_val < CMP_W'(NUM_SLOTS);
        start_pos = FULL_W'(start_val);
        full      = cnt_reg == CNT_W'(NUM_SLOTS);
        is_add    = req_op_reg == OP_ADD;
    end

    // One bitmap word per cycle: free bits for add, occupied bits for next.
    // Padding past the pool reads as neither free nor occupied.
    always_comb
    begin
        free_vec   = ~occ_reg;
        search_vec = is_add ? PAD_W'(free_vec) : PAD_W'(occ_reg);
        word_base  = {ptr_reg, {BIT_W{1'b0}}};
        word       = search_vec[word_base +: WORD_W];
        low_mask   = (WORD_W'(1) << start_bit_reg) - WORD_W'(1);
        masked     = first_reg ? (word & ~low_mask) : word;
        hit        = |masked;
        hit_pos    = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                hit_pos = BIT_W'(i);
            end
        end
        last_word  = ptr_reg == WPTR_W'(NUM_WORDS - 1);
        found_idx  = {ptr_reg, hit_pos};
        slot_found = found_idx[IDX_W-1:0];
    end

    assign stat.scan_req  = (is_add && !full) ||
                            ((req_op_reg == OP_NEXT) && next_ok && start_ok);
    assign stat.scan_done = hit || last_word;

    // Next values of the pool, scan and response registers.
    always_comb
    begin
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        start_bit_next = start_bit_reg;
        status_next    = status_reg;
        res_idx_next   = res_idx_reg;
        pay_sel_next   = pay_sel_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (cmd.exec)
        begin
            status_next    = ST_OK;
            res_idx_next   = '0;
            pay_sel_next   = 1'b0;
            ptr_next       = '0;
            first_next     = 1'b1;
            start_bit_next = '0;
            unique case (req_op_reg)
                OP_ADD:
                begin
                    if (full)
                    begin
                        status_next  = ST_FULL;
                        res_idx_next = INDEX_W'(NUM_SLOTS);
                    end
                end
                OP_REMOVE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (!occ_reg[slot])
                    begin
                        status_next = ST_NONE;
                    end
                    else
                    begin
                        occ_next[slot] = 1'b0;
                        cnt_next       = cnt_reg - CNT_W'(1);
                    end
                end
                OP_GET:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (!occ_reg[slot])
                    begin
                        status_next = ST_NONE;
                    end
                    else
                    begin
                        pay_sel_next = 1'b1;
                        mem_re       = 1'b1;
                    end
                end
                OP_NEXT:
                begin
                    res_idx_next   = INDEX_W'(NUM_SLOTS);
                    ptr_next       = start_pos[FULL_W-1:BIT_W];
                    start_bit_next = start_pos[BIT_W-1:0];
                    if (!next_ok)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (!start_ok)
                    begin
                        status_next = ST_NONE;
                    end
                end
                OP_CLEAR:
                begin
                    occ_next = '0;
                    cnt_next = '0;
                end
                default:
                begin
                    status_next = ST_RANGE;
                end
            endcase
        end

        // Scan step: stop at the first hit or after the last word.
        if (cmd.scan)
        begin
            if (hit)
            begin
                status_next  = ST_OK;
                res_idx_next = INDEX_W'(found_idx);
                if (is_add)
                begin
                    occ_next[slot_found] = 1'b1;
                    cnt_next             = cnt_reg + CNT_W'(1);
                    mem_we               = 1'b1;
                end
            end
            else if (last_word)
            begin
                status_next  = is_add ? ST_FULL : ST_NONE;
                res_idx_next = INDEX_W'(NUM_SLOTS);
            end
            else
            begin
                ptr_next   = ptr_reg + WPTR_W'(1);
                first_next = 1'b0;
            end
        end
    end

    // Control and pool state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            first_reg     <= 1'b1;
            start_bit_reg <= '0;
        end
        else
        begin
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            first_reg     <= first_next;
            start_bit_reg <= start_bit_next;
        end
    end

    // Request and response registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg  <= op;
            req_idx_reg <= slot_index;
            req_pay_reg <= PAYLOAD_BITS'(payload_in);
        end
        status_reg  <= status_next;
        res_idx_reg <= res_idx_next;
        pay_sel_reg <= pay_sel_next;
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[slot_found] <= req_pay_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[slot];
        end
    end

    // Response fields.
    assign status         = status_reg;
    assign result_index   = res_idx_reg;
    assign payload_out    = pay_sel_reg ? PORT_PAY_W'(rdata_reg) : '0;
    assign occupied_count = INDEX_W'(cnt_reg);

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the bitmap slot allocator
// Requests are driven on the valid/ready request channel and every accepted
// transfer is run through a shadow copy of the pool, which yields the response
// that the block must return. Each response transfer is compared field by
// field with the oldest outstanding prediction. Directed cases come first,
// then a full fill of the pool, long random mixes, a receiver stall, a
// drained pause and a stretch without idling.
// ----------------------------------------------------------------------------
module tb;
    import sab_pkg::*;

    localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int FROM_START  = -1;

    // Request codes that the block does not define.
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_C = 3'd7;

    localparam logic [INDEX_W-1:0] NO_SLOT = INDEX_W'(NUM_SLOTS);

    typedef struct packed {
        status_t                status;
        logic [INDEX_W-1:0]     index;
        logic [PORT_PAY_W-1:0]  payload;
        logic [INDEX_W-1:0]     count;
    } response_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [OP_W-1:0]             op = OP_ADD;
    logic signed [INDEX_W-1:0]   slot_index = '0;
    logic [PORT_PAY_W-1:0]       payload_in = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic [INDEX_W-1:0]          result_index;
    logic [PORT_PAY_W-1:0]       payload_out;
    logic [INDEX_W-1:0]          occupied_count;

    // Shadow copy of the pool.
    bit                          shadow_used [NUM_SLOTS];
    logic [PORT_PAY_W-1:0]       shadow_payload [NUM_SLOTS];
    int                          shadow_count = 0;

    response_t                   pending_responses [$];
    int                          error_count = 0;
    int                          cycle_count = 0;
    bit                          sender_idle_en = 1'b1;
    bit                          receiver_idle_en = 1'b1;
    bit                          hold_request = 1'b0;

    slot_allocator_bitmap dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .slot_index     (slot_index),
        .payload_in     (payload_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_index   (result_index),
        .payload_out    (payload_out),
        .occupied_count (occupied_count)
    );

    always #1 clk = ~clk;

    // Applies one request to the shadow pool and returns the response it gives.
    function automatic response_t pool_response(input logic [OP_W-1:0] req_op,
                                                input logic signed [INDEX_W-1:0] req_index,
                                                input logic [PORT_PAY_W-1:0] req_payload);
        response_t r;
        int        pos;
        int        start;
        bit        in_range;
        start = int'(req_index);
        in_range = (start >= 0) && (start < NUM_SLOTS);
        r.status = ST_OK;
        r.index = '0;
        r.payload = '0;
        case (req_op)
            OP_ADD:
            begin
                pos = 0;
                while (pos < NUM_SLOTS && shadow_used[pos])
                    pos++;
                if (pos >= NUM_SLOTS)
                begin
                    r.status = ST_FULL;
                    r.index = NO_SLOT;
                end
                else
                begin
                    shadow_used[pos] = 1'b1;
                    shadow_payload[pos] = req_payload;
                    shadow_count++;
                    r.index = INDEX_W'(pos);
                end
            end
            OP_REMOVE:
            begin
                if (!in_range)
                    r.status = ST_RANGE;
                else if (!shadow_used[start])
                    r.status = ST_NONE;
                else
                begin
                    shadow_used[start] = 1'b0;
                    shadow_count--;
                end
            end
            OP_GET:
            begin
                if (!in_range)
                    r.status = ST_RANGE;
                else if (!shadow_used[start])
                    r.status = ST_NONE;
                else
                    r.payload = shadow_payload[start];
            end
            OP_NEXT:
            begin
                r.index = NO_SLOT;
                if (start < FROM_START || start >= NUM_SLOTS)
                    r.status = ST_RANGE;
                else
                begin
                    pos = start + 1;
                    while (pos < NUM_SLOTS && !shadow_used[pos])
                        pos++;
                    if (pos >= NUM_SLOTS)
                        r.status = ST_NONE;
                    else
                        r.index = INDEX_W'(pos);
                end
            end
            OP_CLEAR:
            begin
                foreach (shadow_used[i])
                    shadow_used[i] = 1'b0;
                shadow_count = 0;
            end
            default:
                r.status = ST_RANGE;
        endcase
        r.count = INDEX_W'(shadow_count);
        return r;
    endfunction

    // Picks an occupied slot where there is one, so that remove and get hit.
    function automatic int pick_slot();
        int base;
        base = $urandom_range(0, NUM_SLOTS - 1);
        if (shadow_count != 0)
            for (int k = 0; k < NUM_SLOTS; k++)
                if (shadow_used[(base + k) % NUM_SLOTS])
                    return (base + k) % NUM_SLOTS;
        return base;
    endfunction

    // Offers one request and waits for its transfer, then records the prediction.
    task automatic issue_request(input logic [OP_W-1:0] req_op, input int req_index,
                                 input logic [PORT_PAY_W-1:0] req_payload);
        logic signed [INDEX_W-1:0] idx9;
        idx9 = req_index[INDEX_W-1:0];
        if (sender_idle_en)
            while ($urandom_range(0, 99) < 8)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid   <= 1'b1;
        op         <= req_op;
        slot_index <= idx9;
        payload_in <= req_payload;
        do
            @(posedge clk);
        while (!in_ready);
        pending_responses.push_back(pool_response(req_op, idx9, req_payload));
    endtask

    // Lowers valid and waits until every outstanding response has arrived.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    // Each extreme of the fields, every request code and each corner case.
    task automatic test_directed_cases();
        issue_request(OP_GET, 0, $urandom);
        issue_request(OP_REMOVE, 0, $urandom);
        issue_request(OP_NEXT, FROM_START, $urandom);
        issue_request(OP_ADD, 0, 32'h0000_0000);
        issue_request(OP_ADD, 255, 32'hFFFF_FFFF);
        issue_request(OP_ADD, FROM_START, 32'hA5A5_5A5A);
        issue_request(OP_GET, 0, $urandom);
        issue_request(OP_GET, 1, $urandom);
        issue_request(OP_GET, 255, $urandom);
        issue_request(OP_GET, -1, $urandom);
        issue_request(OP_GET, -256, $urandom);
        issue_request(OP_REMOVE, -1, $urandom);
        issue_request(OP_REMOVE, 255, $urandom);
        issue_request(OP_REMOVE, 1, $urandom);
        issue_request(OP_ADD, 0, 32'h1234_5678);
        issue_request(OP_NEXT, FROM_START, $urandom);
        issue_request(OP_NEXT, 0, $urandom);
        issue_request(OP_NEXT, 2, $urandom);
        issue_request(OP_NEXT, 255, $urandom);
        issue_request(OP_NEXT, -2, $urandom);
        issue_request(OP_NEXT, -256, $urandom);
        issue_request(OP_UNUSED_A, FROM_START, 32'hFFFF_FFFF);
        issue_request(OP_UNUSED_B, 0, $urandom);
        issue_request(OP_UNUSED_C, 255, $urandom);
        issue_request(OP_CLEAR, 0, $urandom);
        issue_request(OP_GET, 0, $urandom);
    endtask

    // Fills the whole pool, adds to a full pool and refills freed holes.
    task automatic test_fill_pool();
        issue_request(OP_CLEAR, 0, $urandom);
        for (int n = 0; n < NUM_SLOTS; n++)
        begin
            issue_request(OP_ADD, 0, $urandom);
            if ($urandom_range(0, 7) == 0)
                issue_request(OP_GET, pick_slot(), $urandom);
        end
        repeat (2)
            issue_request(OP_ADD, 0, $urandom);
        issue_request(OP_GET, 255, $urandom);
        issue_request(OP_NEXT, 254, $urandom);
        issue_request(OP_NEXT, FROM_START, $urandom);
        repeat (6)
        begin
            issue_request(OP_REMOVE, $urandom_range(0, NUM_SLOTS - 1), $urandom);
            issue_request(OP_ADD, 0, $urandom);
        end
        issue_request(OP_REMOVE, 255, $urandom);
        issue_request(OP_NEXT, 254, $urandom);
        issue_request(OP_ADD, 0, $urandom);
    endtask

    // Random requests, mostly aimed at occupied slots, with some noise.
    task automatic test_random_mix(input int count);
        int roll;
        int idx;
        logic [OP_W-1:0] code;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 999);
            if (roll < 5)
                code = OP_CLEAR;
            else if (roll < 25)
                code = OP_W'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
            else if (roll < 375)
                code = OP_ADD;
            else if (roll < 575)
                code = OP_REMOVE;
            else if (roll < 775)
                code = OP_GET;
            else
                code = OP_NEXT;
            roll = $urandom_range(0, 9);
            if (code == OP_NEXT)
                idx = (roll < 8) ? int'($urandom_range(0, NUM_SLOTS)) - 1
                                 : int'($urandom_range(0, 511));
            else if (roll < 8)
                idx = pick_slot();
            else if (roll < 9)
                idx = $urandom_range(0, NUM_SLOTS - 1);
            else
                idx = $urandom_range(0, 511);
            issue_request(code, idx, $urandom);
        end
    endtask

    // The receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure();
        hold_request = 1'b1;
        test_random_mix(40);
    endtask

    // The sender pauses until every response is in, then carries on.
    task automatic test_drain_pause();
        wait_for_drain();
        test_random_mix(30);
    endtask

    // Back-to-back transfers on both channels.
    task automatic test_no_idle(input int count);
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
        test_random_mix(count);
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
    endtask

    // Response ready, with random idling and an occasional long hold-off.
    always @(posedge clk)
    begin : receiver
        static int hold_left = 0;
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (receiver_idle_en)
            out_ready <= ($urandom_range(0, 99) >= 8);
        else
            out_ready <= 1'b1;
    end

    // Compares each response transfer with the oldest prediction.
    always @(posedge clk)
    begin : response_check
        response_t want;
        if (out_valid === 1'b1 && out_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response transfer with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (result_index !== want.index)
                begin
                    $error("result_index: expected %0d, got %0d", want.index, result_index);
                    error_count++;
                end
                if (payload_out !== want.payload)
                begin
                    $error("payload_out: expected %h, got %h", want.payload, payload_out);
                    error_count++;
                end
                if (occupied_count !== want.count)
                begin
                    $error("occupied_count: expected %0d, got %0d", want.count, occupied_count);
                    error_count++;
                end
            end
        end
    end

    // Guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_fill_pool();
        test_random_mix(700);
        test_backpressure();
        test_drain_pause();
        test_no_idle(250);
        test_random_mix(500);
        wait_for_drain();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_responses.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
